@@ src/usb_lsfs_line_receiver_defines.svh @@
`ifndef USB_LSFS_LINE_RECEIVER_DEFINES_SVH
`define USB_LSFS_LINE_RECEIVER_DEFINES_SVH
// assertion helpers
`define ULR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ULR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ src/ulr_pkg.sv @@
`timescale 1ns / 1ps
package ulr_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SYNC_BITS = 16;
	localparam logic [2:0] STUFF_RUN = 3'd6;
	localparam logic [15:0] PRE_PATTERN = 16'h013C;
	localparam logic [2:0] CFG_SPEED = 3'd0;
	localparam logic [2:0] CFG_FSW = 3'd1;
	localparam logic [2:0] CFG_LSW = 3'd2;
	localparam logic [2:0] CFG_RST = 3'd3;
	localparam logic [2:0] CFG_KA = 3'd4;
	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_FULL = 2'd1;
	localparam logic [1:0] MODE_LOW = 2'd2;
	localparam logic [1:0] MODE_LOW_RP = 2'd3;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BIT = 2'd1;
	localparam logic [1:0] ST_EOP = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;
	localparam logic [2:0] SY_J = 3'd0;
	localparam logic [2:0] SY_K = 3'd1;
	localparam logic [2:0] SY_SE0 = 3'd2;
	localparam logic [2:0] SY_SE1 = 3'd3;
	localparam logic [2:0] SY_FSJ = 3'd4;
	localparam logic [2:0] SY_LSJ = 3'd5;
	localparam logic [3:0] EV_SOP = 4'd4;
	localparam logic [3:0] EV_EOP = 4'd5;
	localparam logic [3:0] EV_BIT = 4'd6;
	localparam logic [3:0] EV_STUFF = 4'd7;
	localparam logic [3:0] EV_STUFF_ERR = 4'd8;
	localparam logic [3:0] EV_EOP_ERR = 4'd9;
	localparam logic [3:0] EV_KEEPALIVE = 4'd10;
	localparam logic [3:0] EV_RESET = 4'd11;

	typedef struct packed {
		logic [3:0]  kind;
		logic        bit_value;
		logic [31:0] start_sample;
		logic [31:0] end_sample;
		logic        last_of_run;
	} ev_t;

	typedef struct packed {
		logic [1:0]  speed_option;
		logic [31:0] fs_width;
		logic [31:0] ls_width;
		logic [23:0] reset_thr;
		logic [23:0] ka_thr;
	} cfg_t;

	function automatic logic [2:0] symbol_of(input logic [1:0] mode, input logic [1:0] pins);
		logic low;
		low = (mode == MODE_LOW) || (mode == MODE_LOW_RP);
		if (pins == 2'd0) return SY_SE0;
		if (pins == 2'd3) return SY_SE1;
		if (pins == 2'd1) return low ? SY_K : ((mode == MODE_FULL) ? SY_J : SY_FSJ);
		return low ? SY_J : ((mode == MODE_FULL) ? SY_K : SY_LSJ);
	endfunction
endpackage

@@ src/ulr_stream_if.sv @@
`timescale 1ns / 1ps
interface ulr_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/ulr_core.sv @@
`timescale 1ns / 1ps
module ulr_core import ulr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] pins,
	input  cfg_t       cfg,
	output ev_t        ev [3],
	output logic [1:0] ev_cnt
);
	localparam int PW = 32 + FRAC_BITS;

	logic [1:0]    line_q, mode_q, edge_pins_q, prev_pins_q;
	logic [2:0]    prev_sym_q, ones_run_q;
	logic [31:0]   cnt_q, width_q, target_q, edge_q, last_edge_q, block_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   hist_q;
	logic [4:0]    hcnt_q;
	logic          seen_q;

	logic [1:0]    line_d, mode_d, edge_pins_d;
	logic [2:0]    prev_sym_d, ones_run_d;
	logic [31:0]   width_d, target_d, edge_d, last_edge_d, block_d;
	logic [PW-1:0] pos_d;
	logic [15:0]   hist_d;
	logic [4:0]    hcnt_d;

	ev_t  evs [3];
	logic [1:0] nev;

	always_comb begin
		logic [1:0] opt, m;
		logic [2:0] sym, es;
		logic [31:0] n, len, d, w, dpv;
		logic [32:0] wg;
		logic [47:0] dw;
		logic [41:0] dp;
		logic b, do_sop, do_idle;
		logic [2:0] sop_sym;
		n = cnt_q;
		line_d = line_q; mode_d = mode_q; edge_pins_d = edge_pins_q;
		prev_sym_d = prev_sym_q; ones_run_d = ones_run_q;
		width_d = width_q; target_d = target_q; edge_d = edge_q;
		last_edge_d = last_edge_q; block_d = block_q; pos_d = pos_q;
		hist_d = hist_q; hcnt_d = hcnt_q;
		for (int i = 0; i < 3; i++) evs[i] = '0;
		nev = 2'd0;
		opt = (cfg.speed_option == 2'd1) ? MODE_FULL :
			(cfg.speed_option == 2'd2) ? MODE_LOW : MODE_AUTO;
		do_sop = 1'b0; do_idle = 1'b0; sop_sym = SY_J; sym = SY_J;
		len = '0; d = '0; b = 1'b0; es = SY_J; w = '0; wg = '0; dw = '0; dp = '0;
		dpv = '0; m = MODE_AUTO;
		if (!seen_q) begin
			edge_d = n;
			sym = symbol_of(opt, pins);
			m = (opt != MODE_AUTO) ? opt : (sym == SY_FSJ) ? MODE_FULL :
				(sym == SY_LSJ) ? MODE_LOW : MODE_AUTO;
			mode_d = m;
			if (m == MODE_LOW || m == MODE_LOW_RP) width_d = cfg.ls_width;
			else if (m == MODE_FULL) width_d = cfg.fs_width;
			prev_sym_d = SY_J;
			edge_pins_d = pins;
		end else if (line_q == ST_IDLE) begin
			if (pins != prev_pins_q) begin
				sym = symbol_of(mode_q, pins);
				edge_pins_d = pins;
				if (sym == SY_SE0) begin
					last_edge_d = n;
					line_d = ST_WAIT;
				end else begin
					do_sop = 1'b1; sop_sym = sym;
				end
			end
		end else if (line_q == ST_WAIT) begin
			if (pins != 2'd0) begin
				edge_pins_d = pins;
				if ((n - last_edge_q) > 32'd1) do_idle = 1'b1;
				else begin
					do_sop = 1'b1; sop_sym = symbol_of(mode_q, pins);
				end
			end
		end else begin
			d = target_q - n;
			if (n == edge_q) edge_pins_d = pins;
			if (d == 32'd0 || d[31]) begin
				sym = symbol_of(mode_q, pins);
				pos_d = pos_q + PW'(width_q);
				target_d = pos_d[PW-1:FRAC_BITS];
				last_edge_d = edge_q;
				edge_d = 32'((pos_d - PW'(width_q >> 1)) >> FRAC_BITS);
				prev_sym_d = sym;
				if (line_q == ST_BIT) begin
					b = (prev_sym_q == sym);
					if (sym == SY_SE0) begin
						line_d = ST_EOP;
						block_d = last_edge_d;
						evs[0] = '{{1'b0, SY_SE0}, 1'b0, last_edge_d, edge_d, 1'b1};
						nev = 2'd1;
					end else begin
						if (ones_run_q == STUFF_RUN) begin
							if (!b) begin
								evs[0] = '{EV_STUFF, 1'b0, last_edge_d, edge_d, 1'b0};
								ones_run_d = '0;
							end else begin
								evs[0] = '{EV_STUFF_ERR, 1'b0, last_edge_d, edge_d, 1'b0};
								line_d = ST_IDLE;
							end
						end else begin
							evs[0] = '{EV_BIT, b, last_edge_d, edge_d, 1'b0};
							ones_run_d = b ? ones_run_q + 3'd1 : 3'd0;
						end
						evs[1] = '{{1'b0, sym}, 1'b0, last_edge_d, edge_d, 1'b1};
						nev = 2'd2;
						if (line_d != ST_IDLE) begin
							if (hcnt_q < 5'(SYNC_BITS)) begin
								hist_d = {hist_q[14:0], b};
								hcnt_d = hcnt_q + 5'd1;
							end
							if (hcnt_d == 5'(SYNC_BITS) && hist_d == PRE_PATTERN) begin
								evs[1].last_of_run = 1'b0;
								evs[2] = '{EV_EOP, 1'b0, edge_d, edge_d, 1'b1};
								nev = 2'd3;
								mode_d = MODE_LOW_RP;
								width_d = cfg.ls_width;
								prev_sym_d = SY_J;
								line_d = ST_IDLE;
							end else if (!b) begin
								es = symbol_of(mode_q, edge_pins_d);
								if (es == SY_J || es == SY_K) begin
									dw = (48'(width_q) * 48'd66) >> 16;
									if (es == sym) w = width_q - dw[31:0];
									else begin
										wg = {1'b0, width_q} + {1'b0, dw[31:0]};
										w = wg[32] ? 32'hFFFF_FFFF : wg[31:0];
									end
									width_d = w;
									dp = (42'(w) * 42'd655) >> 16;
									dpv = dp[31:0];
									if (es == sym) pos_d = pos_d - PW'(dpv);
									else pos_d = pos_d + PW'(dpv);
								end
							end
						end
					end
				end else begin
					evs[0] = '{{1'b0, sym}, 1'b0, last_edge_d, edge_d, 1'b1};
					nev = 2'd1;
					if (sym != SY_SE0) begin
						evs[0].last_of_run = 1'b0;
						nev = 2'd2;
						if (mode_q != MODE_AUTO && sym == SY_J) begin
							evs[1] = '{EV_EOP, 1'b0, block_q, edge_d, 1'b1};
							line_d = ST_WAIT;
						end else begin
							evs[1] = '{EV_EOP_ERR, 1'b0, block_q, edge_d, 1'b1};
							line_d = ST_IDLE;
						end
					end
				end
			end
		end
		if (do_idle) begin
			len = n - last_edge_q;
			edge_d = n;
			if (len > {8'd0, cfg.reset_thr}) begin
				evs[0] = '{EV_RESET, 1'b0, last_edge_q, n, 1'b1}; nev = 2'd1;
			end else if (len > {8'd0, cfg.ka_thr} && mode_q == MODE_LOW) begin
				evs[0] = '{EV_KEEPALIVE, 1'b0, last_edge_q, n, 1'b1}; nev = 2'd1;
			end
			sym = symbol_of(MODE_AUTO, pins);
			m = (opt != MODE_AUTO) ? opt : (sym == SY_FSJ) ? MODE_FULL :
				(sym == SY_LSJ) ? MODE_LOW : MODE_AUTO;
			mode_d = m;
			if (m == MODE_LOW || m == MODE_LOW_RP) width_d = cfg.ls_width;
			else if (m == MODE_FULL) width_d = cfg.fs_width;
			prev_sym_d = SY_J;
			line_d = ST_IDLE;
		end
		if (do_sop && mode_q != MODE_AUTO && sop_sym == SY_K && prev_sym_q == SY_J) begin
			ones_run_d = '0; hcnt_d = '0; hist_d = '0;
			w = (mode_q == MODE_FULL) ? cfg.fs_width : cfg.ls_width;
			width_d = w;
			pos_d = ({n, FRAC_BITS'(0)} - PW'(w >> 1)) + (PW'(1) << (FRAC_BITS - 1));
			pos_d = pos_d + PW'(w);
			target_d = pos_d[PW-1:FRAC_BITS];
			last_edge_d = edge_d;
			edge_d = 32'((pos_d - PW'(w >> 1)) >> FRAC_BITS);
			evs[0] = '{EV_SOP, 1'b0, edge_d, edge_d, 1'b1};
			nev = 2'd1;
			line_d = ST_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= ST_IDLE; mode_q <= MODE_AUTO; prev_sym_q <= SY_J;
			cnt_q <= '0; width_q <= '0; pos_q <= '0; target_q <= '0;
			edge_q <= '0; last_edge_q <= '0; block_q <= '0; edge_pins_q <= '0;
			ones_run_q <= '0; hist_q <= '0; hcnt_q <= '0; seen_q <= 1'b0;
			prev_pins_q <= '0; ev_cnt <= '0;
		end else begin
			ev_cnt <= 2'd0;
			if (step) begin
				line_q <= line_d; mode_q <= mode_d; prev_sym_q <= prev_sym_d;
				cnt_q <= cnt_q + 32'd1; width_q <= width_d; pos_q <= pos_d;
				target_q <= target_d; edge_q <= edge_d; last_edge_q <= last_edge_d;
				block_q <= block_d; edge_pins_q <= edge_pins_d;
				ones_run_q <= ones_run_d; hist_q <= hist_d; hcnt_q <= hcnt_d;
				seen_q <= 1'b1; prev_pins_q <= pins; ev_cnt <= nev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) for (int i = 0; i < 3; i++) ev[i] <= evs[i];
	end
endmodule

@@ src/ulr_out_queue.sv @@
`timescale 1ns / 1ps
module ulr_out_queue import ulr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ev_t        ev [3],
	input  logic [1:0] ev_cnt,
	output logic       room,
	ulr_stream_if.source res
);
	localparam int DEPTH = 8;
	ev_t        mem_q [DEPTH];
	logic [2:0] wp_q, rp_q;
	logic [3:0] fill_q;
	logic       pop;

	assign pop = res.valid && res.ready;
	assign res.valid = fill_q != 4'd0;
	assign res.data = mem_q[rp_q];
	assign room = (fill_q - {3'd0, pop}) <= 4'd2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < ev_cnt) mem_q[wp_q + 3'(i)] <= ev[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; fill_q <= '0;
		end else begin
			wp_q <= wp_q + {1'b0, ev_cnt};
			rp_q <= rp_q + {2'd0, pop};
			fill_q <= fill_q + {2'd0, ev_cnt} - {3'd0, pop};
		end
	end
endmodule

@@ src/usb_lsfs_line_receiver.sv @@
`timescale 1ns / 1ps
// USB low/full-speed line receiver: takes one D+/D- sample per cycle and
// emits line, bit and packet events. Each sample is decoded by the core's
// single-pass logic; its up to three events enter an eight-entry
// result queue. A sample is taken every cycle while no more than two events
// stay queued after this cycle's output transfer, which leaves room for the
// events of the sample in flight and of the new one. The events of a sample
// are registered in the core, then queued, before they are offered.
module usb_lsfs_line_receiver import ulr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ulr_stream_if.sink  samples,
	ulr_stream_if.source events,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	cfg_t       cfg_q;
	ev_t        ev [3];
	logic [1:0] ev_cnt;
	logic       room, step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{2'd0, 32'd546133, 32'd4369067, 24'd250, 24'd120};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPEED: cfg_q.speed_option <= cfg_data[1:0];
				CFG_FSW:   cfg_q.fs_width <= cfg_data;
				CFG_LSW:   cfg_q.ls_width <= cfg_data;
				CFG_RST:   cfg_q.reset_thr <= cfg_data[23:0];
				CFG_KA:    cfg_q.ka_thr <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign samples.ready = room;
	assign step = samples.valid && room;

	ulr_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .pins(samples.data),
		.cfg(cfg_q), .ev(ev), .ev_cnt(ev_cnt)
	);

	ulr_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .ev(ev), .ev_cnt(ev_cnt), .room(room), .res(events)
	);
endmodule

@@ src/ulr_checker.sv @@
`timescale 1ns / 1ps
`include "usb_lsfs_line_receiver_defines.svh"
module ulr_checker import ulr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [69:0] out_data
);
	`ULR_ASSERT_IMP(a_kind, clk, arst_n, out_valid, out_data[69:66] <= EV_RESET)
	`ULR_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`ULR_ASSERT_IMP(a_bit, clk, arst_n, out_valid && out_data[69:66] != EV_BIT, !out_data[65])
	`ULR_ASSERT_IMP(a_rdy, clk, arst_n, !out_valid, in_ready)
endmodule

bind usb_lsfs_line_receiver ulr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(samples.ready),
	.out_valid(events.valid), .out_ready(events.ready), .out_data(events.data)
);
